### design/ble_pkg.sv
// shared types, codes and defaults for the bounded list engine
package ble_pkg;

	localparam int unsigned DEF_CAPACITY = 16;
	localparam int unsigned VAL_W = 32;

	localparam logic [2:0] CMD_ADD_HEAD = 3'd0;
	localparam logic [2:0] CMD_ADD_TAIL = 3'd1;
	localparam logic [2:0] CMD_RM_HEAD  = 3'd2;
	localparam logic [2:0] CMD_PEEK     = 3'd3;
	localparam logic [2:0] CMD_SEARCH   = 3'd4;
	localparam logic [2:0] CMD_RM_KEY   = 3'd5;
	localparam logic [2:0] CMD_CLEAR    = 3'd6;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	typedef struct packed {
		logic [2:0]              command;
		logic signed [VAL_W-1:0] item_value;
	} ble_req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic [1:0]              status;
		logic [4:0]              entry_count;
	} ble_rsp_t;

	typedef struct packed {
		logic                    add_head;
		logic                    add_tail;
		logic                    drop;
		logic                    clr;
		logic signed [VAL_W-1:0] data;
	} ble_ctl_t;

endpackage

### design/ble_cell.sv
// one list cell: holds an entry, compares it with the key and shifts with its neighbours
module ble_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ble_pkg::ble_ctl_t                 ctl,
	input  logic signed [ble_pkg::VAL_W-1:0]  left_value,
	input  logic                              left_valid,
	input  logic signed [ble_pkg::VAL_W-1:0]  right_value,
	input  logic                              right_valid,
	input  logic                              match_in,
	output logic                              match_out,
	output logic signed [ble_pkg::VAL_W-1:0]  value,
	output logic                              valid
);
	import ble_pkg::*;

	logic signed [VAL_W-1:0] value_q;
	logic                    valid_q;
	logic                    hit;
	logic                    shift;

	assign hit       = valid_q && (value_q == ctl.data);
	assign match_out = match_in || hit;
	assign shift     = ctl.drop && match_out;
	assign value     = value_q;
	assign valid     = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end else if (ctl.add_head) begin
			valid_q <= left_valid;
		end else if (ctl.add_tail && !valid_q && left_valid) begin
			valid_q <= 1'b1;
		end else if (shift) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add_head) begin
			value_q <= left_value;
		end else if (ctl.add_tail && !valid_q && left_valid) begin
			value_q <= ctl.data;
		end else if (shift) begin
			value_q <= right_value;
		end
	end

endmodule

### design/bounded_list_engine.sv
// top level: command decode, cell row, entry count and result register
//
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req (command, item_value)
//  result  | rsp_valid | rsp_stall | rsp (result_value, status, entry_count)
//
// one command per cycle while the result is not stalled; its result is registered and shown the next cycle
// the key match ripples through the cell row, so the row length sets the path
// reset empties the list at once
// a request is stalled only while a result is held and stalled itself
module bounded_list_engine #(
	parameter int unsigned CAPACITY = ble_pkg::DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ble_pkg::ble_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ble_pkg::ble_rsp_t rsp
);
	import ble_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	ble_ctl_t                ctl;
	logic                    fire;
	logic                    empty;
	logic                    full;
	logic                    found;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_d;
	ble_rsp_t                rsp_d;
	ble_rsp_t                rsp_q;
	logic                    rsp_valid_q;
	logic signed [VAL_W-1:0] cell_value [CAPACITY];
	logic [CAPACITY-1:0]     cell_valid;
	logic [CAPACITY:0]       chain;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign fire      = req_valid && !req_stall;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign chain[0]  = (req.command == CMD_RM_HEAD);
	assign found     = chain[CAPACITY];

	always_comb begin
		ctl.add_head = fire && (req.command == CMD_ADD_HEAD) && !full;
		ctl.add_tail = fire && (req.command == CMD_ADD_TAIL) && !full;
		ctl.drop     = fire && (((req.command == CMD_RM_HEAD) && !empty)
		               || (req.command == CMD_RM_KEY));
		ctl.clr      = fire && (req.command == CMD_CLEAR);
		ctl.data     = req.item_value;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] lv;
		logic                    lvd;
		logic signed [VAL_W-1:0] rv;
		logic                    rvd;
		if (i == 0) begin : g_first
			assign lv  = req.item_value;
			assign lvd = 1'b1;
		end else begin : g_mid
			assign lv  = cell_value[i-1];
			assign lvd = cell_valid[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rv  = '0;
			assign rvd = 1'b0;
		end else begin : g_inner
			assign rv  = cell_value[i+1];
			assign rvd = cell_valid[i+1];
		end
		ble_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_value  (lv),
			.left_valid  (lvd),
			.right_value (rv),
			.right_valid (rvd),
			.match_in    (chain[i]),
			.match_out   (chain[i+1]),
			.value       (cell_value[i]),
			.valid       (cell_valid[i])
		);
	end

	always_comb begin
		count_d            = count_q;
		rsp_d.result_value = '0;
		rsp_d.status       = ST_DONE;
		unique case (req.command) inside
			CMD_ADD_HEAD, CMD_ADD_TAIL: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			CMD_RM_HEAD: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.result_value = cell_value[0];
					count_d            = count_q - 1'b1;
				end
			end
			CMD_PEEK: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.result_value = cell_value[0];
				end
			end
			CMD_SEARCH: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else if (!found) begin
					rsp_d.status = ST_ABSENT;
				end
			end
			CMD_RM_KEY: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else if (!found) begin
					rsp_d.status = ST_ABSENT;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
		rsp_d.entry_count = 5'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == 32'(count_q))
		else $error("entry count differs from occupied cells");

	a_head_first: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> cell_valid[0])
		else $error("non-empty list without a head cell");

	a_fire_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid)
		else $error("accepted command gave no result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |-> full)
		else $error("full status while list has room");

endmodule
